@@ design/gdd_pkg.sv @@
// Shared types, constants and calendar tables for the Gregorian date pair core.
// No dependencies; compile first.
package gdd_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DIFF_W   = 23;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned DNUM_W   = 23;
    localparam int unsigned OFF_W    = 9;
    localparam int unsigned WSUM_W   = 6;
    localparam int unsigned STAGES   = 5;

    localparam int unsigned MAX_YEAR = 9999;

    // floor(v / 25) = (v * RECIP25) >> RECIP25_SHIFT for v below 43690
    localparam int unsigned RECIP25       = 5243;
    localparam int unsigned RECIP25_SHIFT = 17;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [DNUM_W-1:0]  dnum_t;
    typedef logic [DIFF_W-1:0]  diff_t;
    typedef logic [WDAY_W-1:0]  wday_t;
    typedef logic [OFF_W-1:0]   off_t;

    // Load enables for the three day-number stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } dn_en_t;

    // Days in a month outside leap years; 0 for month codes that mean nothing
    function automatic day_t month_length(month_t m);
        day_t len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of a month, leap day not included
    function automatic off_t days_before_month(month_t m);
        off_t n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Residue mod 7 of a small value; 8 is 1 mod 7, so fold octal digits
    function automatic wday_t mod7_small(logic [WSUM_W-1:0] s);
        logic [3:0] t;
        logic [3:0] u;
        t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        u = {3'b000, t[3]} + {1'b0, t[2:0]};
        return (u >= 4'd7) ? WDAY_W'(u - 4'd7) : WDAY_W'(u);
    endfunction

endpackage

@@ design/gdd_req_if.sv @@
// Request channel of the date pair core: two dates per request.
// Depends on gdd_pkg.
interface gdd_req_if;
    logic              valid;
    logic              ready;
    gdd_pkg::day_t     first_day;
    gdd_pkg::month_t   first_month;
    gdd_pkg::year_t    first_year;
    gdd_pkg::day_t     second_day;
    gdd_pkg::month_t   second_month;
    gdd_pkg::year_t    second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );

    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );
endinterface

@@ design/gdd_rsp_if.sv @@
// Response channel of the date pair core: validity flags, difference, weekday.
// Depends on gdd_pkg.
interface gdd_rsp_if;
    logic             valid;
    logic             ready;
    logic             first_valid;
    logic             second_valid;
    gdd_pkg::diff_t   day_difference;
    gdd_pkg::wday_t   first_weekday;

    modport source (
        output valid, first_valid, second_valid, day_difference, first_weekday,
        input  ready
    );

    modport sink (
        input  valid, first_valid, second_valid, day_difference, first_weekday,
        output ready
    );
endinterface

@@ design/gregorian_date_difference_weekday_core.sv @@
// Top level of the Gregorian date pair core: validity, day difference, weekday.
// Depends on gdd_pkg, gdd_req_if, gdd_rsp_if and gdd_day_num.
//
//   channel  direction  handshake      payload
//   req      in         valid / ready  first_day/month/year, second_day/month/year
//   rsp      out        valid / ready  first_valid, second_valid, day_difference,
//                                      first_weekday
//
// Five register stages: three in each day-number unit, then the difference and
// weekday digit sum, then the output register. A request is taken every cycle
// unless a held response backs up. Each stage loads when it is empty or the
// stage after it moves, so bubbles collapse and a held response stalls only
// what is behind it. Reset clears the stage valid bits only; no clearing pass.
module gregorian_date_difference_weekday_core (
    input  logic  clk,
    input  logic  rst_n,
    gdd_req_if.sink   req,
    gdd_rsp_if.source rsp
);
    import gdd_pkg::*;

    // Stage valid bits and load enables
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] ld;

    always_comb
    begin
        ld[STAGES-1] = !v_reg[STAGES-1] || rsp.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
        v_next = v_reg;
        if (ld[0])
        begin
            v_next[0] = req.valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (ld[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req.ready = ld[0];

    // Day numbers of both dates
    dn_en_t dn_en;
    dnum_t  n1;
    dnum_t  n2;
    logic   ok1;
    logic   ok2;

    assign dn_en = '{s1: ld[0], s2: ld[1], s3: ld[2]};

    gdd_day_num u_first (
        .clk     (clk),
        .en      (dn_en),
        .day     (req.first_day),
        .month   (req.first_month),
        .year    (req.first_year),
        .dnum    (n1),
        .date_ok (ok1)
    );

    gdd_day_num u_second (
        .clk     (clk),
        .en      (dn_en),
        .day     (req.second_day),
        .month   (req.second_month),
        .year    (req.second_year),
        .dnum    (n2),
        .date_ok (ok2)
    );

    // Stage 4: difference, and octal digit sum of day number + 1 for the weekday
    // (day 1 is a Monday, which is weekday 2)
    logic [DNUM_W:0]   n1p;
    logic [WSUM_W-1:0] wsum;
    diff_t             diff4_reg;
    logic [WSUM_W-1:0] wsum4_reg;
    logic              ok1_4_reg;
    logic              ok2_4_reg;

    always_comb
    begin
        n1p  = {1'b0, n1} + (DNUM_W+1)'(1);
        wsum = '0;
        for (int i = 0; i < (DNUM_W + 1) / 3; i++)
        begin
            wsum = wsum + WSUM_W'(n1p[3*i +: 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            diff4_reg <= DIFF_W'(n2 - n1);
            wsum4_reg <= wsum;
            ok1_4_reg <= ok1;
            ok2_4_reg <= ok2;
        end
    end

    // Stage 5: output register; drop difference and weekday unless both dates hold
    logic  both_ok;
    logic  fv5_reg;
    logic  sv5_reg;
    diff_t diff5_reg;
    wday_t wd5_reg;

    assign both_ok = ok1_4_reg && ok2_4_reg;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            fv5_reg   <= ok1_4_reg;
            sv5_reg   <= ok2_4_reg;
            diff5_reg <= both_ok ? diff4_reg : '0;
            wd5_reg   <= both_ok ? mod7_small(wsum4_reg) : '0;
        end
    end

    assign rsp.valid          = v_reg[STAGES-1];
    assign rsp.first_valid    = fv5_reg;
    assign rsp.second_valid   = sv5_reg;
    assign rsp.day_difference = diff5_reg;
    assign rsp.first_weekday  = wd5_reg;

`ifndef SYNTHESIS
    // An empty output stage must let requests in
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[STAGES-1] |-> req.ready)
        else $error("request stalled with empty output stage");

    // An accepted request occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> v_reg[0])
        else $error("accepted request not captured");

    // Invalid dates give zero difference and weekday
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !(rsp.first_valid && rsp.second_valid))
            |-> (rsp.day_difference == '0 && rsp.first_weekday == '0))
        else $error("nonzero result for invalid date");

    // Weekday stays within Saturday to Friday
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.first_weekday <= WDAY_W'(6)))
        else $error("weekday out of range");

    // A stalled third stage keeps its valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && !ld[2]) |=> v_reg[2])
        else $error("stalled stage lost its request");
`endif

endmodule

@@ design/gdd_day_num.sv @@
// Three-stage day number unit: date check and days since 0001-01-01 (that day is 1).
// Depends on gdd_pkg; the stage enables come from the top-level pipeline control.
module gdd_day_num (
    input  logic             clk,
    input  gdd_pkg::dn_en_t  en,
    input  gdd_pkg::day_t    day,
    input  gdd_pkg::month_t  month,
    input  gdd_pkg::year_t   year,
    output gdd_pkg::dnum_t   dnum,
    output logic             date_ok
);
    import gdd_pkg::*;

    localparam int unsigned PY_W = YEAR_W + 13;       // year times reciprocal
    localparam int unsigned X_W  = YEAR_W - 2;        // (year-1)/4
    localparam int unsigned PX_W = X_W + 13;
    localparam int unsigned QY_W = PY_W - RECIP25_SHIFT;
    localparam int unsigned QX_W = PX_W - RECIP25_SHIFT;

    // Stage 1: year-1, quarter, and divisions by 25
    year_t             p;
    logic [X_W-1:0]    x;
    logic [PY_W-1:0]   prod_y;
    logic [PX_W-1:0]   prod_x;

    day_t              d1_reg;
    month_t            m1_reg;
    year_t             y1_reg;
    year_t             p1_reg;
    logic [X_W-1:0]    x1_reg;
    logic [QY_W-1:0]   qy1_reg;
    logic [QX_W-1:0]   qx1_reg;

    assign p      = year - YEAR_W'(1);
    assign x      = p[YEAR_W-1:2];
    assign prod_y = PY_W'(year) * PY_W'(RECIP25);
    assign prod_x = PX_W'(x) * PX_W'(RECIP25);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            d1_reg  <= day;
            m1_reg  <= month;
            y1_reg  <= year;
            p1_reg  <= p;
            x1_reg  <= x;
            qy1_reg <= prod_y[PY_W-1:RECIP25_SHIFT];
            qx1_reg <= prod_x[PX_W-1:RECIP25_SHIFT];
        end
    end

    // Stage 2: leap rule, date check, day-of-year offset, 365 * (year-1)
    logic              div4;
    logic              div25;
    logic              div100;
    logic              div400;
    logic              leap;
    day_t              len;
    logic              ok;
    off_t              off;
    dnum_t             a;

    dnum_t             a2_reg;
    logic [X_W-1:0]    x2_reg;
    logic [QX_W-1:0]   qx2_reg;
    off_t              off2_reg;
    logic              ok2_reg;

    always_comb
    begin
        div4   = (y1_reg[1:0] == 2'b00);
        div25  = (YEAR_W'(qy1_reg) * YEAR_W'(25) == y1_reg);
        div100 = div4 && div25;
        div400 = div25 && (y1_reg[3:0] == 4'b0000);
        leap   = div400 || (div4 && !div100);
        len    = month_length(m1_reg) + DAY_W'((m1_reg == MONTH_FEB) && leap);
        ok     = (y1_reg >= YEAR_W'(1)) && (y1_reg <= YEAR_W'(MAX_YEAR))
              && (m1_reg >= MONTH_JAN) && (m1_reg <= MONTH_DEC)
              && (d1_reg >= DAY_W'(1)) && (d1_reg <= len);
        off    = days_before_month(m1_reg) + OFF_W'((m1_reg > MONTH_FEB) && leap)
              + OFF_W'(d1_reg);
        a      = DNUM_W'(p1_reg) * DNUM_W'(365);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            a2_reg   <= a;
            x2_reg   <= x1_reg;
            qx2_reg  <= qx1_reg;
            off2_reg <= off;
            ok2_reg  <= ok;
        end
    end

    // Stage 3: sum up the day number
    dnum_t             n_next;
    dnum_t             dnum_reg;
    logic              ok3_reg;

    assign n_next = a2_reg + DNUM_W'(x2_reg) - DNUM_W'(qx2_reg)
                  + DNUM_W'(qx2_reg[QX_W-1:2]) + DNUM_W'(off2_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dnum_reg <= n_next;
            ok3_reg  <= ok2_reg;
        end
    end

    assign dnum    = dnum_reg;
    assign date_ok = ok3_reg;

endmodule
